@@ hdl/hotkey_match_table_defines.svh @@
// Assertion macros shared by the hotkey match table RTL.
`ifndef HOTKEY_MATCH_TABLE_DEFINES_SVH
`define HOTKEY_MATCH_TABLE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define HMT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define HMT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/hmt_pkg.sv @@
// Types, codes and constants of the hotkey match table.
`default_nettype none
package hmt_pkg;

	localparam int HMT_ENTRIES = 64;

	localparam logic [2:0] MODE_ADD       = 3'd0;
	localparam logic [2:0] MODE_REMOVE    = 3'd1;
	localparam logic [2:0] MODE_REMOVE_EV = 3'd2;
	localparam logic [2:0] MODE_FILTER    = 3'd3;
	localparam logic [2:0] MODE_LOOKUP    = 3'd4;

	localparam logic [1:0] STATUS_DONE      = 2'd0;
	localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
	localparam logic [1:0] STATUS_FULL      = 2'd3;

	localparam logic [31:0] HMT_SHIFT_MASK   = 32'h0000_0001;
	localparam logic [31:0] HMT_CONTROL_MASK = 32'h0000_0004;
	localparam logic [31:0] HMT_MOD1_MASK    = 32'h0000_0008;
	localparam logic [31:0] HMT_SUPER_MASK   = 32'h0400_0000;
	localparam logic [31:0] HMT_HYPER_MASK   = 32'h0800_0000;
	localparam logic [31:0] HMT_RELEASE_MASK = 32'h4000_0000;
	localparam logic [31:0] HMT_MASK_RESET   = 32'h4C00_000D;

	localparam logic [28:0] KEY_SHIFT_L   = 29'h0FFE1;
	localparam logic [28:0] KEY_SHIFT_R   = 29'h0FFE2;
	localparam logic [28:0] KEY_CONTROL_L = 29'h0FFE3;
	localparam logic [28:0] KEY_CONTROL_R = 29'h0FFE4;
	localparam logic [28:0] KEY_META_L    = 29'h0FFE7;
	localparam logic [28:0] KEY_META_R    = 29'h0FFE8;
	localparam logic [28:0] KEY_ALT_L     = 29'h0FFE9;
	localparam logic [28:0] KEY_ALT_R     = 29'h0FFEA;
	localparam logic [28:0] KEY_SUPER_L   = 29'h0FFEB;
	localparam logic [28:0] KEY_SUPER_R   = 29'h0FFEC;
	localparam logic [28:0] KEY_HYPER_L   = 29'h0FFED;
	localparam logic [28:0] KEY_HYPER_R   = 29'h0FFEE;

	typedef struct packed {
		logic [2:0]  mode;
		logic [28:0] key_code;
		logic [31:0] key_modifiers;
		logic [28:0] previous_key_code;
		logic [31:0] previous_modifiers;
		logic [15:0] event_id;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] matched_event;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic [28:0] key_code;
		logic [31:0] modifiers;
		logic [15:0] event_id;
	} entry_t;

	function automatic logic [31:0] key_mod_bit(input logic [28:0] key);
		logic [31:0] bits;
		case (key) inside
			KEY_SHIFT_L, KEY_SHIFT_R:                      bits = HMT_SHIFT_MASK;
			KEY_CONTROL_L, KEY_CONTROL_R:                  bits = HMT_CONTROL_MASK;
			KEY_META_L, KEY_META_R, KEY_ALT_L, KEY_ALT_R:  bits = HMT_MOD1_MASK;
			KEY_SUPER_L, KEY_SUPER_R:                      bits = HMT_SUPER_MASK;
			KEY_HYPER_L, KEY_HYPER_R:                      bits = HMT_HYPER_MASK;
			default:                                       bits = '0;
		endcase
		return bits;
	endfunction

endpackage
`default_nettype wire

@@ hdl/hotkey_match_table.sv @@
// Hotkey match table: entry memory, scan sequencer and result register.
`default_nettype none
`include "hotkey_match_table_defines.svh"

// Binds keys (key code plus normalized modifiers) to nonzero event ids in an
// ENTRIES-deep single-port-write memory. After reset a clearing pass runs,
// writing one entry per cycle, before the first request beat is taken;
// configuration beats are taken at any time. Every request then scans the
// whole memory through its one read port, one entry per cycle from a
// registered read, and no new request is taken until the last one's result
// is loaded. Removals write back during the scan; an add writes its free
// slot once the scan ends. The result sits in an output register, so a
// stalled consumer holds only the following result, not the scan.
module hotkey_match_table
	import hmt_pkg::*;
#(
	parameter int ENTRIES = HMT_ENTRIES
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [31:0]  cfg_data,
	input  wire          req_valid,
	output logic         req_ready,
	input  req_t         req,
	output logic         rsp_valid,
	input  wire          rsp_ready,
	output rsp_t         rsp
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] PTR_END  = CW'(ENTRIES);
	localparam logic [CW-1:0] PTR_LAST = CW'(ENTRIES - 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] ptr_q;
	logic [31:0]   mask_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic [2:0]    op_mode_q;
	logic [28:0]   op_key_q;
	logic [31:0]   op_mods_q;
	logic [15:0]   op_ev_q;
	logic          op_search_q;
	logic          found_q;
	logic [15:0]   match_q;
	logic          free_found_q;
	logic [AW-1:0] free_idx_q;
	logic          ev_any_q;

	entry_t        entry_mem_q [ENTRIES];
	entry_t        rd_data_s1;
	logic          rd_valid_s1;
	logic [AW-1:0] addr_s1;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;

	logic          req_fire;
	logic          load;
	logic [31:0]   mods_n;
	logic [31:0]   pmods_n;
	logic          gate_ok;
	logic          entry_hit;
	logic          key_clear;
	logic          ev_clear;
	logic          free_slot;
	logic          add_commit;
	logic [1:0]    status_d;
	logic [15:0]   match_d;

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign load      = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	assign mods_n  = (req.key_modifiers & mask_q) | key_mod_bit(req.key_code);
	assign pmods_n = (req.previous_modifiers & mask_q) | key_mod_bit(req.previous_key_code);

	always_comb begin
		gate_ok = 1'b1;
		if ((mods_n & HMT_RELEASE_MASK) != '0) begin
			if ((pmods_n & HMT_RELEASE_MASK) != '0) begin
				gate_ok = 1'b0;
			end else if (mods_n != (pmods_n | HMT_RELEASE_MASK)) begin
				gate_ok = 1'b0;
			end else if (req.key_code != req.previous_key_code &&
				(key_mod_bit(req.key_code) == '0 ||
				key_mod_bit(req.previous_key_code) == '0)) begin
				gate_ok = 1'b0;
			end
		end
	end

	assign rd_en   = (state_q == ST_SCAN) && (ptr_q != PTR_END);
	assign rd_addr = ptr_q[AW-1:0];

	assign entry_hit = rd_valid_s1 && rd_data_s1.valid && op_search_q &&
		rd_data_s1.key_code == op_key_q && rd_data_s1.modifiers == op_mods_q;
	assign key_clear = entry_hit && (op_mode_q == MODE_REMOVE);
	assign ev_clear  = rd_valid_s1 && rd_data_s1.valid && (op_mode_q == MODE_REMOVE_EV) &&
		rd_data_s1.event_id == op_ev_q && op_ev_q != '0;
	assign free_slot = rd_valid_s1 && !rd_data_s1.valid;
	assign add_commit = load && (op_mode_q == MODE_ADD) && op_ev_q != '0 &&
		!found_q && free_found_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = '0;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = ptr_q[AW-1:0];
		end else if (add_commit) begin
			wr_en   = 1'b1;
			wr_addr = free_idx_q;
			wr_data = '{valid: 1'b1, key_code: op_key_q, modifiers: op_mods_q,
				event_id: op_ev_q};
		end else if (key_clear || ev_clear) begin
			wr_en = 1'b1;
		end
	end

	always_comb begin
		status_d = STATUS_DONE;
		match_d  = '0;
		case (op_mode_q)
			MODE_ADD: begin
				if (op_ev_q == '0) begin
					status_d = STATUS_DONE;
				end else if (found_q) begin
					status_d = STATUS_DUPLICATE;
				end else if (!free_found_q) begin
					status_d = STATUS_FULL;
				end
			end
			MODE_REMOVE: begin
				if (!found_q) begin
					status_d = STATUS_NOT_FOUND;
				end
			end
			MODE_REMOVE_EV: begin
				if (!ev_any_q) begin
					status_d = STATUS_NOT_FOUND;
				end
			end
			MODE_FILTER, MODE_LOOKUP: begin
				if (found_q) begin
					match_d = match_q;
				end
			end
			default: begin
				status_d = STATUS_DONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= entry_mem_q[rd_addr];
		end
		addr_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ptr_q       <= '0;
			mask_q      <= HMT_MASK_RESET;
			rd_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (cfg_valid && cfg_ready) begin
				mask_q <= cfg_data;
			end
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (ptr_q == PTR_LAST) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						ptr_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ptr_q == PTR_END) begin
						state_q <= ST_DONE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (load) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_mode_q    <= req.mode;
			op_key_q     <= req.key_code;
			op_mods_q    <= mods_n;
			op_ev_q      <= req.event_id;
			op_search_q  <= (req.mode != MODE_FILTER) || gate_ok;
			found_q      <= 1'b0;
			match_q      <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			ev_any_q     <= 1'b0;
		end else begin
			if (entry_hit) begin
				found_q <= 1'b1;
				match_q <= rd_data_s1.event_id;
			end
			if (free_slot && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= addr_s1;
			end
			if (ev_clear) begin
				ev_any_q <= 1'b1;
			end
		end
		if (load) begin
			rsp_q <= '{status: status_d, matched_event: match_d};
		end
	end

	`HMT_ASSERT_IMP(a_wr_rd_apart, wr_en && rd_en, wr_addr != rd_addr, "write hits read entry")
	`HMT_ASSERT_IMP(a_key_unique, entry_hit, !found_q, "key stored twice")
	`HMT_ASSERT_IMP(a_zero_ev_kept, state_q == ST_SCAN && op_mode_q == MODE_REMOVE_EV && op_ev_q == '0, !wr_en, "event zero removed entries")
	`HMT_ASSERT_NXT(a_scan_starts, req_fire, state_q == ST_SCAN && ptr_q == '0, "scan did not start")

endmodule
`default_nettype wire

@@ dv/hmt_result_checker.sv @@
// Checker of the hotkey match table: mirrors the table, predicts every response beat and compares.
module hmt_result_checker
	import hmt_pkg::*;
#(
	parameter int ENTRIES = HMT_ENTRIES
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  wire  [31:0] cfg_data,
	input  wire         req_valid,
	input  wire         req_ready,
	input  req_t        req,
	input  wire         rsp_valid,
	input  wire         rsp_ready,
	input  rsp_t        rsp,
	output int          mismatches,
	output int          outstanding
);

	logic [31:0] keep_mask;
	logic        slot_used  [ENTRIES];
	logic [28:0] slot_key   [ENTRIES];
	logic [31:0] slot_mods  [ENTRIES];
	logic [15:0] slot_event [ENTRIES];
	rsp_t        awaited_rsp [$];

	function automatic logic [31:0] implied_modifier(input logic [28:0] key);
		case (key)
			KEY_SHIFT_L, KEY_SHIFT_R:                     return HMT_SHIFT_MASK;
			KEY_CONTROL_L, KEY_CONTROL_R:                 return HMT_CONTROL_MASK;
			KEY_META_L, KEY_META_R, KEY_ALT_L, KEY_ALT_R: return HMT_MOD1_MASK;
			KEY_SUPER_L, KEY_SUPER_R:                     return HMT_SUPER_MASK;
			KEY_HYPER_L, KEY_HYPER_R:                     return HMT_HYPER_MASK;
			default:                                      return '0;
		endcase
	endfunction

	function automatic logic [31:0] normalized(input logic [28:0] key, input logic [31:0] mods);
		return (mods & keep_mask) | implied_modifier(key);
	endfunction

	function automatic int slot_of(input logic [28:0] key, input logic [31:0] mods);
		int found;
		found = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (found < 0 && slot_used[i] && slot_key[i] == key && slot_mods[i] == mods)
				found = i;
		return found;
	endfunction

	function automatic rsp_t apply_request(input req_t item);
		logic [31:0] mods, prev_mods;
		int          hit, free_slot;
		logic        passes;
		rsp_t        result;
		mods      = normalized(item.key_code, item.key_modifiers);
		prev_mods = normalized(item.previous_key_code, item.previous_modifiers);
		hit       = slot_of(item.key_code, mods);
		result.status        = STATUS_DONE;
		result.matched_event = '0;
		case (item.mode)
			MODE_ADD: begin
				free_slot = -1;
				for (int i = ENTRIES - 1; i >= 0; i--)
					if (!slot_used[i])
						free_slot = i;
				if (item.event_id != '0 && hit >= 0) begin
					result.status = STATUS_DUPLICATE;
				end else if (item.event_id != '0 && free_slot < 0) begin
					result.status = STATUS_FULL;
				end else if (item.event_id != '0) begin
					slot_used[free_slot]  = 1'b1;
					slot_key[free_slot]   = item.key_code;
					slot_mods[free_slot]  = mods;
					slot_event[free_slot] = item.event_id;
				end
			end
			MODE_REMOVE: begin
				if (hit >= 0)
					slot_used[hit] = 1'b0;
				else
					result.status = STATUS_NOT_FOUND;
			end
			MODE_REMOVE_EV: begin
				result.status = STATUS_NOT_FOUND;
				for (int i = 0; i < ENTRIES; i++)
					if (item.event_id != '0 && slot_used[i] && slot_event[i] == item.event_id) begin
						slot_used[i]  = 1'b0;
						result.status = STATUS_DONE;
					end
			end
			MODE_FILTER: begin
				passes = 1'b1;
				if ((mods & HMT_RELEASE_MASK) != '0)
					passes = (prev_mods & HMT_RELEASE_MASK) == '0
						&& mods == (prev_mods | HMT_RELEASE_MASK)
						&& (item.key_code == item.previous_key_code
							|| (implied_modifier(item.key_code) != '0
								&& implied_modifier(item.previous_key_code) != '0));
				if (passes && hit >= 0)
					result.matched_event = slot_event[hit];
			end
			MODE_LOOKUP: begin
				if (hit >= 0)
					result.matched_event = slot_event[hit];
			end
			default: begin
			end
		endcase
		return result;
	endfunction

	always @(posedge clk or negedge arst_n) begin : beat_watch
		rsp_t want;
		if (!arst_n) begin
			keep_mask   = HMT_MASK_RESET;
			mismatches  = 0;
			outstanding = 0;
			awaited_rsp.delete();
			for (int i = 0; i < ENTRIES; i++)
				slot_used[i] = 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					mismatches++;
					$display("%0t: response beat with none awaited: status %0d, event 0x%04h",
						$time, rsp.status, rsp.matched_event);
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.status !== want.status) begin
						mismatches++;
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.status, rsp.status);
					end
					if (rsp.matched_event !== want.matched_event) begin
						mismatches++;
						$display("%0t: matched_event mismatch: expected 0x%04h, actual 0x%04h",
							$time, want.matched_event, rsp.matched_event);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				keep_mask = cfg_data;
			if (req_valid && req_ready)
				awaited_rsp.push_back(apply_request(req));
			outstanding = awaited_rsp.size();
		end
	end

endmodule

@@ dv/hotkey_match_table_tb.sv @@
// Testbench top of the hotkey match table: clock, reset, stimulus, receiver stalls and verdict.
module hotkey_match_table_tb;
	import hmt_pkg::*;

	localparam int          CYCLE_LIMIT      = 1_000_000;
	localparam int          PHASES           = 6;
	localparam int          ITEMS_PER_PHASE  = 140;
	localparam int          LONG_HOLD        = 600;
	localparam logic [2:0]  MODE_SPARE_FIRST = 3'd5;
	localparam logic [2:0]  MODE_SPARE_LAST  = 3'd7;
	localparam logic [28:0] KEY_LETTER_A     = 29'h61;
	localparam logic [28:0] KEY_LETTER_B     = 29'h62;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	int          mismatches;
	int          outstanding;
	int          hold_off_requests;
	int          cycles = 0;
	req_t        bound_keys [$];

	hotkey_match_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	hmt_result_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [28:0] modifier_key(input int n);
		case (n)
			0:       return KEY_SHIFT_L;
			1:       return KEY_SHIFT_R;
			2:       return KEY_CONTROL_L;
			3:       return KEY_CONTROL_R;
			4:       return KEY_META_L;
			5:       return KEY_META_R;
			6:       return KEY_ALT_L;
			7:       return KEY_ALT_R;
			8:       return KEY_SUPER_L;
			9:       return KEY_SUPER_R;
			10:      return KEY_HYPER_L;
			default: return KEY_HYPER_R;
		endcase
	endfunction

	function automatic logic [28:0] pick_key();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 7)
			return modifier_key($urandom_range(0, 11));
		if (roll < 16)
			return KEY_LETTER_A + 29'($urandom_range(0, 11));
		if (roll == 16)
			return '0;
		if (roll == 17)
			return '1;
		return 29'($urandom);
	endfunction

	function automatic logic [31:0] pick_mods();
		logic [31:0] mods;
		case ($urandom_range(0, 7))
			0:       mods = '0;
			1:       mods = HMT_SHIFT_MASK;
			2:       mods = HMT_CONTROL_MASK;
			3:       mods = HMT_CONTROL_MASK | HMT_MOD1_MASK;
			4:       mods = HMT_SUPER_MASK | HMT_SHIFT_MASK;
			5:       mods = HMT_HYPER_MASK;
			6:       mods = HMT_RELEASE_MASK | HMT_CONTROL_MASK;
			default: mods = $urandom;
		endcase
		if ($urandom_range(0, 3) == 0)
			mods = mods | ($urandom & 32'h03FF_FFF0);
		return mods;
	endfunction

	function automatic req_t make_item(input logic [2:0] mode, input logic [28:0] key,
		input logic [31:0] mods, input logic [28:0] prev_key, input logic [31:0] prev_mods,
		input logic [15:0] event_id);
		req_t item;
		item.mode               = mode;
		item.key_code           = key;
		item.key_modifiers      = mods;
		item.previous_key_code  = prev_key;
		item.previous_modifiers = prev_mods;
		item.event_id           = event_id;
		return item;
	endfunction

	task automatic offer(input req_t item);
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
	endtask

	task automatic write_mask(input logic [31:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int add_pct, input int count);
		req_t item;
		int   roll, pick, burst;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			if (burst == 0) begin
				if (n != 0) begin
					req_valid <= 1'b0;
					repeat ($urandom_range(1, 80))
						@(negedge clk);
				end
				burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
			end
			burst--;
			roll = $urandom_range(0, 99);
			if (roll < add_pct)
				item.mode = MODE_ADD;
			else if (roll < add_pct + 8)
				item.mode = MODE_REMOVE;
			else if (roll < add_pct + 13)
				item.mode = MODE_REMOVE_EV;
			else if (roll < add_pct + 16)
				item.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
			else
				item.mode = roll[0] ? MODE_FILTER : MODE_LOOKUP;
			item.key_code           = pick_key();
			item.key_modifiers      = pick_mods();
			item.previous_key_code  = pick_key();
			item.previous_modifiers = pick_mods();
			roll = $urandom_range(0, 19);
			item.event_id = (roll < 17) ? 16'($urandom_range(1, 6)) :
				(roll == 17) ? 16'h0000 : (roll == 18) ? 16'hFFFF : 16'($urandom);
			if (item.mode != MODE_ADD && bound_keys.size() != 0 && $urandom_range(0, 9) < 7) begin
				pick = $urandom_range(0, bound_keys.size() - 1);
				item.key_code      = bound_keys[pick].key_code;
				item.key_modifiers = bound_keys[pick].key_modifiers;
				item.event_id      = bound_keys[pick].event_id;
			end
			if (item.mode == MODE_FILTER) begin
				roll = $urandom_range(0, 3);
				if (roll < 2) begin
					item.previous_modifiers = item.key_modifiers & ~HMT_RELEASE_MASK;
					item.key_modifiers      = item.key_modifiers | HMT_RELEASE_MASK;
					item.previous_key_code  = (roll == 0) ? item.key_code :
						modifier_key($urandom_range(0, 11));
				end else if (roll == 2) begin
					item.key_modifiers = item.key_modifiers & ~HMT_RELEASE_MASK;
				end
			end
			if (item.mode == MODE_ADD) begin
				bound_keys.push_back(item);
				if (bound_keys.size() > 40)
					void'(bound_keys.pop_front());
			end
			offer(item);
		end
	endtask

	initial begin : rsp_side
		int style, span, holds_done;
		rsp_ready  = 1'b0;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			style = $urandom_range(0, 3);
			span  = $urandom_range(30, 300);
			repeat (span) begin
				@(negedge clk);
				if (hold_off_requests > holds_done) begin
					holds_done++;
					rsp_ready <= 1'b0;
					repeat (LONG_HOLD)
						@(negedge clk);
				end
				case (style)
					0:       rsp_ready <= 1'b1;
					1:       rsp_ready <= 1'($urandom_range(0, 1));
					2:       rsp_ready <= ($urandom_range(0, 2) == 0);
					default: rsp_ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		localparam logic [31:0] CTRL = HMT_CONTROL_MASK;
		localparam logic [31:0] REL  = HMT_RELEASE_MASK;
		int add_pct;
		arst_n            = 1'b0;
		cfg_valid         = 1'b0;
		cfg_data          = '0;
		req_valid         = 1'b0;
		req               = '0;
		hold_off_requests = 0;
		repeat (10)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		offer(make_item(MODE_LOOKUP, KEY_LETTER_A, CTRL, '0, '0, 16'd1));
		offer(make_item(MODE_ADD, KEY_LETTER_A, CTRL, '0, '0, 16'd1));
		offer(make_item(MODE_ADD, KEY_LETTER_A, CTRL | 32'h0000_0100, '0, '0, 16'd9));
		offer(make_item(MODE_ADD, KEY_LETTER_B, HMT_SHIFT_MASK, '0, '0, 16'd0));
		offer(make_item(MODE_LOOKUP, KEY_LETTER_B, HMT_SHIFT_MASK, '0, '0, 16'd0));
		offer(make_item(MODE_LOOKUP, KEY_LETTER_A, CTRL | 32'h0000_0030, '0, '0, 16'd0));
		offer(make_item(MODE_ADD, KEY_CONTROL_L, '0, '0, '0, 16'd2));
		offer(make_item(MODE_LOOKUP, KEY_CONTROL_L, CTRL, '0, '0, 16'd0));
		offer(make_item(MODE_ADD, KEY_LETTER_A, CTRL | REL, '0, '0, 16'd3));
		offer(make_item(MODE_FILTER, KEY_LETTER_A, CTRL, KEY_LETTER_B, REL, 16'd0));
		offer(make_item(MODE_FILTER, KEY_LETTER_A, CTRL | REL, KEY_LETTER_A, CTRL, 16'd0));
		offer(make_item(MODE_FILTER, KEY_LETTER_A, CTRL | REL, KEY_LETTER_A, CTRL | REL, 16'd0));
		offer(make_item(MODE_FILTER, KEY_LETTER_A, CTRL | REL, KEY_LETTER_A, HMT_SHIFT_MASK, 16'd0));
		offer(make_item(MODE_FILTER, KEY_LETTER_A, CTRL | REL, KEY_LETTER_B, CTRL, 16'd0));
		offer(make_item(MODE_ADD, KEY_CONTROL_R, HMT_SHIFT_MASK | REL, '0, '0, 16'd4));
		offer(make_item(MODE_FILTER, KEY_CONTROL_R, HMT_SHIFT_MASK | REL, KEY_SHIFT_L, CTRL, 16'd0));
		offer(make_item(MODE_REMOVE, KEY_LETTER_A, CTRL, '0, '0, 16'd0));
		offer(make_item(MODE_REMOVE, KEY_LETTER_A, CTRL, '0, '0, 16'd0));
		offer(make_item(MODE_REMOVE_EV, KEY_LETTER_A, CTRL, '0, '0, 16'd0));
		offer(make_item(MODE_REMOVE_EV, '0, '0, '0, '0, 16'd3));
		offer(make_item(MODE_REMOVE_EV, '0, '0, '0, '0, 16'd3));
		offer(make_item(MODE_ADD, '1, '1, '1, '1, 16'hFFFF));
		offer(make_item(MODE_LOOKUP, '1, '1, '1, '1, 16'hFFFF));
		offer(make_item(MODE_ADD, '0, '0, '0, '0, 16'd1));
		for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
			offer(make_item(3'(m), '1, '1, '1, '1, 16'hFFFF));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: add_pct = 70;
				1: begin
					write_mask('1);
					add_pct = 40;
				end
				2: begin
					write_mask($urandom | HMT_RELEASE_MASK);
					add_pct = 20;
				end
				3: begin
					write_mask('0);
					add_pct = 65;
				end
				4: begin
					write_mask(HMT_MASK_RESET);
					add_pct = 30;
				end
				default: begin
					write_mask($urandom);
					add_pct = 45;
				end
			endcase
			if (p == 1 || p == 4)
				hold_off_requests <= hold_off_requests + 1;
			run_phase(add_pct, ITEMS_PER_PHASE);
			drain();
		end

		repeat (3 * HMT_ENTRIES)
			@(negedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/hmt_pkg.sv
hdl/hotkey_match_table.sv
dv/hmt_result_checker.sv
dv/hotkey_match_table_tb.sv
